### hdl/masked_byte_pattern_scanner_macros.svh
// assertion macros for the masked byte pattern scanner
// expects clk_i and rst_ni in the scope of use; empty bodies under SYNTHESIS
`ifndef MASKED_BYTE_PATTERN_SCANNER_MACROS_SVH
`define MASKED_BYTE_PATTERN_SCANNER_MACROS_SVH
`ifndef SYNTHESIS
`define MBPS_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mbps same-cycle check failed");
`define MBPS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mbps next-cycle check failed");
`else
`define MBPS_ASSERT_SAME(lbl, ante, cons)
`define MBPS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### hdl/mbps_pkg.sv
// types and constants of the masked byte pattern scanner
// no dependencies
`default_nettype none
package mbps_pkg;

  localparam int PatternMax = 16;
  localparam int WinDepth   = PatternMax - 1;
  localparam int LenW       = $clog2(PatternMax + 1);
  localparam int PosW       = $clog2(PatternMax);
  localparam int FillW      = $clog2(WinDepth + 1);
  localparam int EntriesPerWord = 4;
  localparam int PatternWords   = PatternMax / EntriesPerWord;

  localparam logic [15:0] CountMax = 16'hFFFF;
  localparam logic [7:0]  ByteMask = 8'hFF;

  typedef enum logic [2:0] {
    CfgPattern0  = 3'd0,
    CfgPattern1  = 3'd1,
    CfgPattern2  = 3'd2,
    CfgPattern3  = 3'd3,
    CfgLength    = 3'd4,
    CfgMinMatch  = 3'd5,
    CfgMaxMatch  = 3'd6,
    CfgModeFlags = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    VerdictNone      = 2'd0,
    VerdictPass      = 2'd1,
    VerdictTolerated = 2'd2,
    VerdictFatal     = 2'd3
  } verdict_e;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [31:0] byte_offset;
    logic        section_first;
    logic        section_executable;
    logic        image_last;
  } in_beat_t;

  typedef struct packed {
    logic        match_found;
    logic [31:0] match_offset;
    logic [15:0] match_total;
    verdict_e    verdict;
  } out_beat_t;

  typedef struct packed {
    logic [7:0] mask;
    logic [7:0] value;
  } pat_entry_t;

endpackage
`default_nettype wire

### hdl/masked_byte_pattern_scanner.sv
// path: input register, one parallel compare stage, result register
// throughput: one byte per cycle while the output is not stalled
// state: input register, 15-byte window, fill count and match counter
// reset: asynchronous active low, clears control, window, count and config
// config registers return to length 1, limits 1/1, executable-only scanning
`default_nettype none
`include "masked_byte_pattern_scanner_macros.svh"
module masked_byte_pattern_scanner import mbps_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_beat_t    in_beat_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_beat_t   out_beat_o
);

  logic [63:0]     pat_q [PatternWords];
  logic [LenW-1:0] len_q;
  logic [15:0]     min_q;
  logic [15:0]     max_q;
  logic [1:0]      mode_q;

  logic            in_valid_q;
  in_beat_t        in_q;
  logic            out_valid_q;
  out_beat_t       out_q;
  out_beat_t       out_d;

  logic [7:0]       win_q [WinDepth];
  logic [FillW-1:0] fill_q;
  logic [FillW-1:0] fill_d;
  logic [15:0]      cnt_q;
  logic [15:0]      cnt_d;

  pat_entry_t       entries [PatternMax];
  logic [LenW-1:0]  len_eff;
  logic [FillW-1:0] fill_eff;
  logic             scanned;
  logic             found;
  logic             adv;
  logic             take;
  logic [15:0]      cnt_inc;
  logic             failed;

  // config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int w = 0; w < PatternWords; w++) begin
        pat_q[w] <= '0;
      end
      len_q  <= LenW'(1);
      min_q  <= 16'd1;
      max_q  <= 16'd1;
      mode_q <= 2'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgPattern0:  pat_q[0] <= cfg_data_i;
        CfgPattern1:  pat_q[1] <= cfg_data_i;
        CfgPattern2:  pat_q[2] <= cfg_data_i;
        CfgPattern3:  pat_q[3] <= cfg_data_i;
        CfgLength:    len_q    <= cfg_data_i[LenW-1:0];
        CfgMinMatch:  min_q    <= cfg_data_i[15:0];
        CfgMaxMatch:  max_q    <= cfg_data_i[15:0];
        CfgModeFlags: mode_q   <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int w = 0; w < PatternWords; w++) begin
      for (int j = 0; j < EntriesPerWord; j++) begin
        entries[w*EntriesPerWord + j].mask  = pat_q[w][16*j+8 +: 8] & ByteMask;
        entries[w*EntriesPerWord + j].value = pat_q[w][16*j   +: 8];
      end
    end
  end

  // handshake
  assign adv        = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !adv;
  assign take       = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (take) begin
      in_valid_q <= 1'b1;
    end else if (adv) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      in_q <= in_beat_i;
    end
  end

  // match stage
  assign len_eff  = (len_q > LenW'(PatternMax)) ? LenW'(PatternMax) : len_q;
  assign fill_eff = in_q.section_first ? '0 : fill_q;
  assign scanned  = (in_q.section_executable == mode_q[0]);

  logic raw_found;

  mbps_match u_match (
    .data_byte_i (in_q.data_byte),
    .window_i    (win_q),
    .fill_i      (fill_eff),
    .len_i       (len_eff),
    .entries_i   (entries),
    .found_o     (raw_found)
  );

  assign found   = scanned && raw_found;
  assign cnt_inc = (found && (cnt_q != CountMax)) ? cnt_q + 16'd1 : cnt_q;
  assign failed  = (cnt_inc < min_q) || (cnt_inc > max_q);

  always_comb begin
    if (in_q.image_last || !scanned) begin
      fill_d = '0;
    end else if (fill_eff == FillW'(WinDepth)) begin
      fill_d = fill_eff;
    end else begin
      fill_d = fill_eff + FillW'(1);
    end
    cnt_d = in_q.image_last ? 16'd0 : cnt_inc;
  end

  always_comb begin
    out_d.match_found  = found;
    out_d.match_offset = found ? (in_q.byte_offset - 32'(len_eff) + 32'd1) : 32'd0;
    out_d.match_total  = cnt_inc;
    if (!in_q.image_last) begin
      out_d.verdict = VerdictNone;
    end else if (!failed) begin
      out_d.verdict = VerdictPass;
    end else if (mode_q[1]) begin
      out_d.verdict = VerdictTolerated;
    end else begin
      out_d.verdict = VerdictFatal;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      cnt_q  <= '0;
      for (int i = 0; i < WinDepth; i++) begin
        win_q[i] <= '0;
      end
    end else if (adv) begin
      fill_q <= fill_d;
      cnt_q  <= cnt_d;
      if (scanned) begin
        win_q[0] <= in_q.data_byte;
        for (int i = 1; i < WinDepth; i++) begin
          win_q[i] <= win_q[i-1];
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

  `MBPS_ASSERT_NEXT(a_adv_fills_out, adv, out_valid_q)
  `MBPS_ASSERT_NEXT(a_last_clears, adv && in_q.image_last, (cnt_q == '0) && (fill_q == '0))
  `MBPS_ASSERT_SAME(a_found_counts, out_valid_q && out_q.match_found, out_q.match_total != '0)
  `MBPS_ASSERT_SAME(a_verdict_on_last, adv && !in_q.image_last, out_d.verdict == VerdictNone)

endmodule
`default_nettype wire

### hdl/mbps_match.sv
// parallel masked compare of the pattern against current byte and window
// depends on mbps_pkg
`default_nettype none
module mbps_match import mbps_pkg::*; (
  input  logic [7:0]       data_byte_i,
  input  logic [7:0]       window_i [WinDepth],
  input  logic [FillW-1:0] fill_i,
  input  logic [LenW-1:0]  len_i,
  input  pat_entry_t       entries_i [PatternMax],
  output logic             found_o
);

  logic [7:0]            hist [PatternMax];
  logic [PatternMax-1:0] ok;
  logic                  enough;

  // hist[0] is the current byte, hist[i] the byte i positions back
  assign hist[0] = data_byte_i;
  for (genvar i = 1; i < PatternMax; i++) begin : g_hist
    assign hist[i] = window_i[i-1];
  end

  for (genvar k = 0; k < PatternMax; k++) begin : g_entry
    logic [PosW-1:0] pos;
    logic [7:0]      sel;
    assign pos   = PosW'(len_i - LenW'(k + 1));
    assign sel   = hist[pos];
    assign ok[k] = (LenW'(k) >= len_i) ||
                   ((sel & entries_i[k].mask) == entries_i[k].value);
  end

  assign enough  = (LenW'(fill_i) + LenW'(1)) >= len_i;
  assign found_o = (len_i != '0) && enough && (&ok);

endmodule
`default_nettype wire

### sim/tb.sv
// testbench for masked_byte_pattern_scanner: directed and random byte streams,
// with an in-line scan predictor checking every result beat field by field
// depends on mbps_pkg and the scanner rtl only
`timescale 1ns / 100ps

module tb;
  import mbps_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [63:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_stall_o;
  in_beat_t    in_beat_i;
  logic        out_valid_o;
  logic        out_stall_i;
  out_beat_t   out_beat_o;

  masked_byte_pattern_scanner DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_beat_i   (in_beat_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_beat_o  (out_beat_o)
  );

  always #4 clk_i = ~clk_i;

  // scanner shadow: configuration and scan state
  logic [63:0]     pat_word [PatternWords];
  logic [LenW-1:0] pat_len;
  logic [15:0]     min_lim;
  logic [15:0]     max_lim;
  logic [1:0]      mode_bits;
  logic [7:0]      win [WinDepth];
  int              fill;
  logic [15:0]     hit_count;

  out_beat_t scan_records [$];
  out_beat_t got;
  out_beat_t want;

  int err_cnt;
  int bytes_sent;
  int images_sent;
  int matches_seen;
  int verdict_cnt [4];
  int send_idle_pct;
  int stall_pct;
  int hold_left;

  function automatic pat_entry_t entry_of(int e);
    return pat_word[e / EntriesPerWord][(e % EntriesPerWord) * 16 +: 16];
  endfunction

  function automatic logic entry_hit(int e, logic [7:0] b);
    pat_entry_t ent;
    ent = entry_of(e);
    return (b & ent.mask) == ent.value;
  endfunction

  function automatic int used_len();
    return (pat_len > PatternMax) ? PatternMax : int'(pat_len);
  endfunction

  function automatic out_beat_t scan_byte(in_beat_t b);
    out_beat_t r;
    int        len;
    logic      hit;
    logic      failed;
    r = '0;
    r.verdict = VerdictNone;
    len = used_len();
    hit = 1'b0;
    if (b.section_first) fill = 0;
    if (b.section_executable == mode_bits[0]) begin
      if (len >= 1 && fill + 1 >= len) begin
        hit = entry_hit(len - 1, b.data_byte);
        for (int k = 0; k + 1 < len; k++) begin
          if (!entry_hit(k, win[len - 2 - k])) hit = 1'b0;
        end
      end
      for (int j = WinDepth - 1; j >= 1; j--) win[j] = win[j - 1];
      win[0] = b.data_byte;
      if (fill < WinDepth) fill++;
    end else begin
      fill = 0;
    end
    if (hit) begin
      r.match_offset = b.byte_offset - 32'(len - 1);
      if (hit_count != CountMax) hit_count++;
      matches_seen++;
    end
    r.match_found = hit;
    r.match_total = hit_count;
    if (b.image_last) begin
      failed = (hit_count < min_lim) || (hit_count > max_lim);
      if (!failed) r.verdict = VerdictPass;
      else if (mode_bits[1]) r.verdict = VerdictTolerated;
      else r.verdict = VerdictFatal;
      verdict_cnt[r.verdict]++;
      hit_count = '0;
      fill = 0;
      images_sent++;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what);
    err_cnt++;
    if (err_cnt <= 40) $display("MISMATCH at %0t: %s", $time, what);
  endtask

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (scan_records.size() == 0) begin
        report_mismatch("result beat with nothing outstanding");
      end else begin
        want = scan_records.pop_front();
        got = out_beat_o;
        if (got.match_found !== want.match_found)
          report_mismatch($sformatf("match_found got %0b want %0b",
                                    got.match_found, want.match_found));
        if (got.match_offset !== want.match_offset)
          report_mismatch($sformatf("match_offset got %h want %h",
                                    got.match_offset, want.match_offset));
        if (got.match_total !== want.match_total)
          report_mismatch($sformatf("match_total got %0d want %0d",
                                    got.match_total, want.match_total));
        if (got.verdict !== want.verdict)
          report_mismatch($sformatf("verdict got %0d want %0d",
                                    got.verdict, want.verdict));
      end
    end
  end

  // receiver stall, with an optional long hold-off
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic send_byte(in_beat_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_beat_i  <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    scan_records.push_back(scan_byte(b));
    bytes_sent++;
  endtask

  task automatic put(logic [7:0] d, logic [31:0] off, logic first, logic exe,
                     logic last);
    in_beat_t b;
    b.data_byte          = d;
    b.byte_offset        = off;
    b.section_first      = first;
    b.section_executable = exe;
    b.image_last         = last;
    send_byte(b);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (scan_records.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [63:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CfgPattern0, CfgPattern1, CfgPattern2, CfgPattern3: pat_word[idx] = data;
      CfgLength:    pat_len   = data[LenW-1:0];
      CfgMinMatch:  min_lim   = data[15:0];
      CfgMaxMatch:  max_lim   = data[15:0];
      CfgModeFlags: mode_bits = data[1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic load_setup(logic [63:0] w0, logic [63:0] w1, logic [63:0] w2,
                            logic [63:0] w3, logic [4:0] len, logic [15:0] lo,
                            logic [15:0] hi, logic [1:0] mode);
    write_reg(CfgPattern0, w0);
    write_reg(CfgPattern1, w1);
    write_reg(CfgPattern2, w2);
    write_reg(CfgPattern3, w3);
    write_reg(CfgLength, 64'(len));
    write_reg(CfgMinMatch, 64'(lo));
    write_reg(CfgMaxMatch, 64'(hi));
    write_reg(CfgModeFlags, 64'(mode));
  endtask

  task automatic load_random_setup();
    logic [63:0] w [PatternWords];
    logic [7:0]  m;
    logic [7:0]  v;
    logic [4:0]  len;
    logic [15:0] lo;
    logic [15:0] hi;
    for (int e = 0; e < PatternMax; e++) begin
      m = ($urandom_range(2) == 0) ? ByteMask : 8'($urandom);
      v = 8'($urandom);
      if ($urandom_range(7) != 0) v &= m;
      w[e / EntriesPerWord][(e % EntriesPerWord) * 16 +: 16] = {m, v};
    end
    for (int k = 0; k < PatternWords; k++) begin
      case ($urandom_range(11))
        0: w[k] = '0;
        1: w[k] = '1;
        default: ;
      endcase
    end
    case ($urandom_range(9))
      0: len = 5'd0;
      1: len = 5'd1;
      2: len = 5'(PatternMax);
      3: len = 5'($urandom_range(PatternMax + 1, 31));
      default: len = 5'($urandom_range(2, 8));
    endcase
    case ($urandom_range(5))
      0: begin lo = '0; hi = CountMax; end
      1: begin lo = CountMax; hi = CountMax; end
      default: begin lo = 16'($urandom_range(5)); hi = 16'($urandom_range(7)); end
    endcase
    load_setup(w[0], w[1], w[2], w[3], len, lo, hi, 2'($urandom_range(3)));
  endtask

  // byte that satisfies entry e, free bits random
  function automatic logic [7:0] fit_entry(int e);
    pat_entry_t ent;
    ent = entry_of(e);
    return (ent.value & ent.mask) | (8'($urandom) & ~ent.mask);
  endfunction

  task automatic send_image(int n);
    in_beat_t   b;
    logic [7:0] planted [$];
    logic [31:0] off;
    logic       exe;
    int         len;
    len = used_len();
    exe = mode_bits[0];
    off = ($urandom_range(7) == 0) ? 32'hFFFF_FFFF - 32'($urandom_range(30))
                                   : $urandom;
    for (int i = 0; i < n; i++) begin
      b.section_first = (i == 0) || ($urandom_range(24) == 0);
      if (b.section_first) exe = ($urandom_range(4) == 0) ? ~mode_bits[0] : mode_bits[0];
      if ($urandom_range(39) == 0) exe = ~exe;
      if (planted.size() == 0 && len > 0 && $urandom_range(4) == 0) begin
        for (int e = 0; e < len; e++) planted.push_back(fit_entry(e));
      end
      b.data_byte = (planted.size() != 0) ? planted.pop_front() : 8'($urandom);
      if ($urandom_range(19) == 0) b.data_byte = 8'($urandom);
      b.section_executable = exe;
      b.byte_offset        = off;
      b.image_last         = (i == n - 1);
      send_byte(b);
      off = ($urandom_range(29) == 0) ? $urandom : off + 1;
    end
  endtask

  task automatic test_reset_values();
    put(8'h00, 32'h0000_0000, 1'b1, 1'b1, 1'b0);
    put(8'hFF, 32'h0000_0001, 1'b0, 1'b0, 1'b0);
    put(8'h5A, 32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1);
    drain();
  endtask

  task automatic test_directed_cases();
    // exact AA AA: overlap, unscanned byte, section break, fatal over max
    load_setup(64'h0000_0000_FFAA_FFAA, '0, '0, '0, 5'd2, 16'd2, 16'd3, 2'b01);
    put(8'hAA, 32'd0, 1'b1, 1'b1, 1'b0);
    put(8'hAA, 32'd1, 1'b0, 1'b1, 1'b0);
    put(8'hAA, 32'd2, 1'b0, 1'b1, 1'b0);
    put(8'hAA, 32'd3, 1'b0, 1'b0, 1'b0);
    put(8'hAA, 32'd4, 1'b0, 1'b1, 1'b0);
    put(8'hAA, 32'd5, 1'b1, 1'b1, 1'b0);
    put(8'hAA, 32'd6, 1'b0, 1'b1, 1'b0);
    put(8'hAA, 32'd7, 1'b0, 1'b1, 1'b1);
    drain();
    // no pattern at all, non-executable bytes left unscanned, tolerated failure
    load_setup('1, '1, '1, '1, 5'd0, 16'd2, 16'd3, 2'b11);
    put(8'hFF, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0);
    put(8'h00, 32'h0000_0000, 1'b0, 1'b0, 1'b1);
    drain();
    // match start wraps below zero, min above max
    load_setup('0, '0, '0, '0, 5'd2, 16'd5, 16'd2, 2'b00);
    put(8'h12, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0);
    put(8'h34, 32'h0000_0000, 1'b0, 1'b0, 1'b1);
    drain();
    // partial masks
    load_setup(64'h0000_0000_0F05_F0A0, '0, '0, '0, 5'd2, 16'd0, CountMax, 2'b10);
    put(8'hA7, 32'd100, 1'b1, 1'b0, 1'b0);
    put(8'hC5, 32'd101, 1'b0, 1'b0, 1'b0);
    put(8'hB5, 32'd102, 1'b0, 1'b0, 1'b0);
    put(8'hAF, 32'd103, 1'b0, 1'b1, 1'b0);
    put(8'hA0, 32'd104, 1'b0, 1'b0, 1'b0);
    put(8'h05, 32'd105, 1'b0, 1'b0, 1'b1);
    drain();
  endtask

  task automatic test_backpressure();
    load_setup('0, '0, '0, '0, 5'd3, 16'd0, CountMax, 2'b01);
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_left     = 150;
    send_image(80);
    drain();
  endtask

  task automatic test_random_traffic();
    int idle_tab [4];
    int stall_tab [4];
    int target;
    idle_tab  = '{0, 51, 0, 27};
    stall_tab = '{0, 0, 51, 27};
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = idle_tab[p];
      stall_pct     = stall_tab[p];
      target = bytes_sent + 280;
      while (bytes_sent < target) begin
        drain();
        load_random_setup();
        repeat ($urandom_range(1, 3)) send_image($urandom_range(4, 60));
      end
    end
    drain();
  endtask

  initial begin
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= CfgPattern0;
    cfg_data_i  <= '0;
    in_valid_i  <= 1'b0;
    in_beat_i   <= '0;
    out_stall_i <= 1'b0;
    for (int k = 0; k < PatternWords; k++) pat_word[k] = '0;
    for (int j = 0; j < WinDepth; j++) win[j] = '0;
    pat_len   = 1;
    min_lim   = 16'd1;
    max_lim   = 16'd1;
    mode_bits = 2'b01;
    fill      = 0;
    hit_count = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_values();
    test_directed_cases();
    test_backpressure();
    test_random_traffic();

    repeat (4) @(posedge clk_i);
    $display("covered %0d bytes in %0d images with %0d matches, lengths 0 to 31,",
             bytes_sent, images_sent, matches_seen);
    $display("verdicts pass/tolerated/fatal %0d/%0d/%0d, long stall",
             verdict_cnt[VerdictPass], verdict_cnt[VerdictTolerated],
             verdict_cnt[VerdictFatal]);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
